### design/mrt_pkg.sv
// Package for the mapped region table: request and response types, the slot record,
// sequencer states and fixed constants. No dependencies.
`timescale 1ns / 1ps
package mrt_pkg;

    localparam int ADDR_BITS = 38;
    localparam int LEN_BITS  = 31;
    localparam int OFF_BITS  = 32;

    localparam logic [ADDR_BITS-1:0] BASE_RESET  = 38'h10_0000_0000;
    localparam logic [ADDR_BITS-1:0] LIMIT_RESET = 38'h3F_FFFF_E000;

    localparam logic [1:0] OP_MAP   = 2'd0;
    localparam logic [1:0] OP_FAULT = 2'd1;
    localparam logic [1:0] OP_UNMAP = 2'd2;

    localparam logic [3:0] CAUSE_FETCH = 4'd12;
    localparam logic [3:0] CAUSE_LOAD  = 4'd13;
    localparam logic [3:0] CAUSE_STORE = 4'd15;

    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0]           op;
        logic [ADDR_BITS-1:0] address;
        logic [LEN_BITS-1:0]  byte_length;
        logic [LEN_BITS-1:0]  map_offset;
        logic [2:0]           rights;
        logic [1:0]           map_kind;
        logic [3:0]           fault_cause;
        logic                 file_mappable;
        logic                 file_writable;
    } t_req;

    typedef struct packed {
        logic                 status;
        logic [ADDR_BITS-1:0] region_start;
        logic [3:0]           slot_index;
        logic [OFF_BITS-1:0]  page_file_offset;
        logic [4:0]           pte_bits;
        logic                 region_shared;
        logic                 region_freed;
    } t_rsp;

    // One table entry as held in the slot memory; kind is 1 for private.
    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [LEN_BITS-1:0]  length;
        logic [2:0]           rights;
        logic                 kind;
        logic [OFF_BITS-1:0]  data_offset;
    } t_slot;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EV,
        ST_WB,
        ST_DONE
    } t_state;

endpackage

### design/mapped_region_table_unit.sv
// Mapped region table: slot memory, used bits, request sequencer and result register.
// Depends on mrt_pkg.
`timescale 1ns / 1ps
// Usage
// Requests enter on i_in_valid / o_in_stall with the payload i_in_req; results leave on
// o_out_valid / i_out_stall as o_out_rsp, exactly one result per request, in order.
// Map, fault and unmap walk the slot memory one slot at a time: each slot passes through
// a read state and an evaluate state. A map walks every slot, then writes its new slot
// in the write-back state if it fits below the limit; a fault or unmap stops at the first
// hit, and a request rejected on its arguments goes straight to the result state.
// One request is worked on at a time; the next one is taken as soon as the result has
// moved into the output register, even while that register is still stalled.
// map_base and map_limit are written through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must do so only while the block is idle, as the block itself does not enforce it.
// Reset (synchronous, active low) marks every slot free, restores both registers to
// their defaults and empties the output register. Slot contents are not cleared, as a
// free slot's contents are never used. A stalled result holds steady until taken.
module mapped_region_table_unit #(
    parameter int SLOTS      = 16,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  mrt_pkg::t_req                i_in_req,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output mrt_pkg::t_rsp                o_out_rsp,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [mrt_pkg::ADDR_BITS-1:0] i_cfg_data
);

    localparam int AB = mrt_pkg::ADDR_BITS;
    localparam int LB = mrt_pkg::LEN_BITS;
    localparam int OB = mrt_pkg::OFF_BITS;
    localparam int EW = AB + 2;
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [EW-1:0] PG_MASK_E = EW'((64'd1 << PAGE_SHIFT) - 64'd1);

    mrt_pkg::t_state        r_state, n_state;
    mrt_pkg::t_req          r_req, n_req;
    mrt_pkg::t_rsp          r_res, n_res;
    mrt_pkg::t_rsp          r_out;
    logic                   r_out_valid;
    logic [SLOTS-1:0]       r_used, n_used;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [IW-1:0]          r_free, n_free;
    logic [EW-1:0]          r_best, n_best;
    logic [AB-1:0]          r_base, r_limit;
    mrt_pkg::t_slot         r_mem [SLOTS];
    mrt_pkg::t_slot         r_rdata;

    logic                   in_acc, out_free;
    logic                   arg_ok, unmap_ok, free_found;
    logic [IW-1:0]          free_idx;
    logic [IW-1:0]          idx;
    logic                   ev_used, last;
    logic [EW-1:0]          len_round, ev_end, wb_sum;
    logic [AB:0]            reg_end, rng_end;
    logic                   f_hit, f_ok, u_hit, u_head, u_tail;
    logic [AB-1:0]          page;
    logic [4:0]             pte;
    logic                   mem_we;
    mrt_pkg::t_slot         mem_wdata;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != mrt_pkg::ST_IDLE);
    assign idx        = r_cnt[IW-1:0];
    assign last       = (r_cnt == CW'(SLOTS - 1));
    assign ev_used    = r_used[idx];

    // Lowest free slot.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // Argument checks made when a request is taken.
    always_comb begin
        arg_ok = (i_in_req.address == '0) && (i_in_req.byte_length != '0)
              && (i_in_req.map_offset == '0) && !i_in_req.map_kind[1]
              && (i_in_req.rights != '0) && i_in_req.file_mappable
              && !(!i_in_req.map_kind[0] && i_in_req.rights[1] && !i_in_req.file_writable);
        unmap_ok = (i_in_req.byte_length != '0)
                && (i_in_req.address[PAGE_SHIFT-1:0] == '0);
    end

    // Evaluation of the slot just read.
    always_comb begin
        len_round = (EW'(r_req.byte_length) + PG_MASK_E) & ~PG_MASK_E;
        reg_end   = {1'b0, r_rdata.start} + (AB+1)'(r_rdata.length);
        rng_end   = {1'b0, r_req.address} + (AB+1)'(r_req.byte_length);
        ev_end    = (EW'(reg_end) + PG_MASK_E) & ~PG_MASK_E;
        wb_sum    = r_best + len_round;
        f_hit     = (r_req.address >= r_rdata.start) && ({1'b0, r_req.address} < reg_end);
        f_ok      = !((r_req.fault_cause == mrt_pkg::CAUSE_LOAD  && !r_rdata.rights[0])
                   || (r_req.fault_cause == mrt_pkg::CAUSE_STORE && !r_rdata.rights[1])
                   || (r_req.fault_cause == mrt_pkg::CAUSE_FETCH && !r_rdata.rights[2]));
        u_hit     = (r_req.address >= r_rdata.start) && (rng_end <= reg_end);
        u_head    = (r_req.address == r_rdata.start);
        u_tail    = (rng_end == reg_end);
        page      = r_req.address & ~AB'(PG_MASK_E);
        pte       = {1'b1, r_rdata.rights, 1'b0};
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mrt_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_req.op)
                        mrt_pkg::OP_MAP:
                            n_state = (arg_ok && free_found) ? mrt_pkg::ST_RD
                                                             : mrt_pkg::ST_DONE;
                        mrt_pkg::OP_FAULT: n_state = mrt_pkg::ST_RD;
                        mrt_pkg::OP_UNMAP:
                            n_state = unmap_ok ? mrt_pkg::ST_RD : mrt_pkg::ST_DONE;
                        default: n_state = mrt_pkg::ST_DONE;
                    endcase
                end
            end
            mrt_pkg::ST_RD: n_state = mrt_pkg::ST_EV;
            mrt_pkg::ST_EV: begin
                if (ev_used && r_req.op == mrt_pkg::OP_FAULT && f_hit) begin
                    n_state = mrt_pkg::ST_DONE;
                end else if (ev_used && r_req.op == mrt_pkg::OP_UNMAP && u_hit) begin
                    n_state = mrt_pkg::ST_DONE;
                end else if (last) begin
                    n_state = (r_req.op == mrt_pkg::OP_MAP) ? mrt_pkg::ST_WB
                                                            : mrt_pkg::ST_DONE;
                end else begin
                    n_state = mrt_pkg::ST_RD;
                end
            end
            mrt_pkg::ST_WB: n_state = mrt_pkg::ST_DONE;
            mrt_pkg::ST_DONE: if (out_free) n_state = mrt_pkg::ST_IDLE;
            default: n_state = mrt_pkg::ST_IDLE;
        endcase
    end

    // Datapath updates, result building and write-back.
    always_comb begin
        n_req     = r_req;
        n_res     = r_res;
        n_used    = r_used;
        n_cnt     = r_cnt;
        n_free    = r_free;
        n_best    = r_best;
        mem_we    = 1'b0;
        mem_wdata = r_rdata;
        case (r_state)
            mrt_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_req        = i_in_req;
                    n_res        = '0;
                    n_res.status = 1'b1;
                    n_cnt        = '0;
                    n_free       = free_idx;
                    n_best       = EW'(r_base);
                end
            end
            mrt_pkg::ST_EV: begin
                n_cnt = r_cnt + CW'(1);
                if (ev_used) begin
                    case (r_req.op)
                        mrt_pkg::OP_MAP: if (ev_end > r_best) n_best = ev_end;
                        mrt_pkg::OP_FAULT: begin
                            if (f_hit && f_ok) begin
                                n_res.status           = 1'b0;
                                n_res.slot_index       = 4'(idx);
                                n_res.page_file_offset = r_rdata.data_offset
                                                       + OB'(page - r_rdata.start);
                                n_res.pte_bits         = pte;
                                n_res.region_shared    = !r_rdata.kind;
                            end
                        end
                        mrt_pkg::OP_UNMAP: begin
                            if (u_hit && (u_head || u_tail)) begin
                                n_res.status        = 1'b0;
                                n_res.slot_index    = 4'(idx);
                                n_res.region_shared = !r_rdata.kind;
                                if (u_head && u_tail) begin
                                    n_res.region_freed = 1'b1;
                                    n_used[idx]        = 1'b0;
                                end else if (u_head) begin
                                    mem_we                = 1'b1;
                                    mem_wdata.start       = r_rdata.start
                                                          + AB'(r_req.byte_length);
                                    mem_wdata.data_offset = r_rdata.data_offset
                                                          + OB'(r_req.byte_length);
                                    mem_wdata.length      = r_rdata.length
                                                          - r_req.byte_length;
                                end else begin
                                    mem_we           = 1'b1;
                                    mem_wdata.length = LB'(r_req.address - r_rdata.start);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            mrt_pkg::ST_WB: begin
                if ({1'b0, wb_sum} < (EW+1)'(r_limit)) begin
                    mem_we                = 1'b1;
                    mem_wdata.start       = AB'(r_best);
                    mem_wdata.length      = r_req.byte_length;
                    mem_wdata.rights      = r_req.rights;
                    mem_wdata.kind        = r_req.map_kind[0];
                    mem_wdata.data_offset = '0;
                    n_used[r_free]        = 1'b1;
                    n_res.status          = 1'b0;
                    n_res.region_start    = AB'(r_best);
                    n_res.slot_index      = 4'(r_free);
                end
            end
            default: ;
        endcase
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[(r_state == mrt_pkg::ST_WB) ? r_free : idx] <= mem_wdata;
        end
        r_rdata <= r_mem[idx];
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_res  <= n_res;
        r_cnt  <= n_cnt;
        r_free <= n_free;
        r_best <= n_best;
        if (r_state == mrt_pkg::ST_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mrt_pkg::ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_base      <= mrt_pkg::BASE_RESET;
            r_limit     <= mrt_pkg::LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (r_state == mrt_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we && i_cfg_index == mrt_pkg::CFG_BASE) r_base <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == mrt_pkg::CFG_LIMIT) r_limit <= i_cfg_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

`ifndef SYNTHESIS
    // A rejected result carries nothing but its status.
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.status |->
            o_out_rsp.region_start == '0 && o_out_rsp.slot_index == '0
            && o_out_rsp.pte_bits == '0 && o_out_rsp.region_freed == 1'b0)
        else $error("rejected result has nonzero fields");

    // The slot counter stays inside the table while the walk runs.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mrt_pkg::ST_RD || r_state == mrt_pkg::ST_EV) |-> r_cnt < CW'(SLOTS))
        else $error("slot counter out of range");

    // A successful map marks its slot used.
    a_map_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mrt_pkg::ST_WB && mem_we |=> r_used[$past(r_free)])
        else $error("mapped slot not marked used");

    // A new request is only taken from the idle state.
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != mrt_pkg::ST_IDLE)
        else $error("request taken without leaving idle");
`endif

endmodule
